### rtl/core/wildcard_byte_pattern_scanner_unit_macros.svh
// Assertion macros used by the wildcard byte pattern scanner RTL.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WBPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/wbps_pkg.sv
// Types and constants shared by the wildcard byte pattern scanner modules.
package wbps_pkg;

  // Largest pattern the token store holds.
  localparam int MaxPattern = 128;
  // Width of the running buffer offset counter.
  localparam int OffsetWidth = 32;
  // Width of the reported match offset.
  localparam int MatchWidth = 32;
  // Width of the pattern length register.
  localparam int CfgWidth = 8;
  // Width of the token index field.
  localparam int TokIdxWidth = 7;

  localparam int PatIdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int LenW = $clog2(MaxPattern + 1);
  localparam int WideW = (OffsetWidth > MatchWidth) ? OffsetWidth : MatchWidth;

  typedef enum logic {
    OpLoad = 1'b0,
    OpScan = 1'b1
  } op_e;

  typedef struct packed {
    op_e                    opcode;
    logic [TokIdxWidth-1:0] token_index;
    logic [7:0]             token_byte;
    logic                   token_wildcard;
    logic [7:0]             data_byte;
    logic                   first_of_buffer;
  } req_t;

endpackage

### rtl/core/wbps_in_stage.sv
// Input register that holds one accepted request until the match core takes it.
module wbps_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  wbps_pkg::req_t req_i,
  input  logic          take_i,
  output logic          valid_o,
  output wbps_pkg::req_t req_o
);

  logic           valid_q, valid_d;
  wbps_pkg::req_t req_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

### rtl/core/wbps_match_core.sv
// Token store, shift-and partial match vector and offset counter.
module wbps_match_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wbps_pkg::req_t                      req_i,
  input  logic                                fire_i,
  input  logic [wbps_pkg::LenW-1:0]           len_i,
  output logic                                hit_o,
  output logic [wbps_pkg::MatchWidth-1:0]     offset_o
);

  logic [7:0]                        val_q [wbps_pkg::MaxPattern];
  logic [wbps_pkg::MaxPattern-1:0]   wild_q;
  logic [wbps_pkg::MaxPattern-1:0]   vec_q, vec_d, vec_base;
  logic [wbps_pkg::OffsetWidth-1:0]  pos_q, pos_d, pos_base;
  logic [wbps_pkg::OffsetWidth-1:0]  start;
  logic [wbps_pkg::WideW-1:0]        start_wide;
  logic [wbps_pkg::PatIdxW-1:0]      last_idx;
  logic [wbps_pkg::PatIdxW-1:0]      wr_idx;
  logic                              is_scan, wr_en;

  assign is_scan  = (req_i.opcode == wbps_pkg::OpScan);
  assign vec_base = req_i.first_of_buffer ? '0 : vec_q;
  assign pos_base = req_i.first_of_buffer ? '0 : pos_q;

  // Each token position extends the match that ended one byte earlier.
  for (genvar k = 0; k < wbps_pkg::MaxPattern; k++) begin : g_cell
    logic prev, tok_hit, in_use;
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_tail
      assign prev = vec_base[k-1];
    end
    assign tok_hit = wild_q[k] || (val_q[k] == req_i.data_byte);
    assign in_use  = (k < int'(len_i));
    assign vec_d[k] = in_use && prev && tok_hit;
  end

  assign last_idx = wbps_pkg::PatIdxW'(len_i - 1'b1);
  assign hit_o    = is_scan && (len_i != '0) && vec_d[last_idx];

  assign start      = pos_base - wbps_pkg::OffsetWidth'(len_i) + 1'b1;
  assign start_wide = wbps_pkg::WideW'(start);
  assign offset_o   = start_wide[wbps_pkg::MatchWidth-1:0];
  assign pos_d      = pos_base + 1'b1;

  assign wr_idx = wbps_pkg::PatIdxW'(req_i.token_index);
  assign wr_en  = fire_i && !is_scan && (int'(req_i.token_index) < wbps_pkg::MaxPattern);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= '0;
      pos_q <= '0;
    end else if (fire_i && is_scan) begin
      vec_q <= vec_d;
      pos_q <= pos_d;
    end
  end

  // The token store has no reset; a token is defined once it is loaded.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      val_q[wr_idx]  <= req_i.token_byte;
      wild_q[wr_idx] <= req_i.token_wildcard;
    end
  end

endmodule

### rtl/core/wbps_out_stage.sv
// Result register that holds one match offset until the consumer takes it.
module wbps_out_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic [wbps_pkg::MatchWidth-1:0] offset_i,
  output logic                            free_o,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [wbps_pkg::MatchWidth-1:0] offset_o
);

  logic                            valid_q, valid_d;
  logic [wbps_pkg::MatchWidth-1:0] offset_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      offset_q <= offset_i;
    end
  end

  assign valid_o  = valid_q;
  assign offset_o = offset_q;

endmodule

### rtl/core/wildcard_byte_pattern_scanner_unit.sv
// Top level of the wildcard byte pattern scanner.
//
// The scanner searches a byte stream for a pattern of up to 128 tokens, each a
// literal byte or a wildcard that matches any byte. A request with opcode load
// writes one token into the store; a request with opcode scan presents one
// buffer byte, and first_of_buffer restarts the offset at zero and drops all
// partial matches before that byte is compared. Every window whose bytes match
// the pattern, overlapping windows included, produces one result carrying the
// offset of the window's first byte; the offset counter wraps at 32 bits. The
// pattern length register, written over the configuration channel, sets how
// many tokens are in use; zero disables matching and values above 128 act as
// 128. Write it and load tokens only while no request is in flight. The block
// takes one request every cycle unless a scan is held up by a waiting result;
// a result is offered on the output once its request has passed through the
// input register, where the match core compares all token positions at once,
// and the result register has taken the offset, from where the consumer can
// take it. While a result waits in the result register, scans back up into
// the input register, but load requests keep moving. Tokens that were never
// loaded compare as unknown values.
module wildcard_byte_pattern_scanner_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               opcode_i,
  input  logic [wbps_pkg::TokIdxWidth-1:0]   token_index_i,
  input  logic [7:0]                         token_byte_i,
  input  logic                               token_wildcard_i,
  input  logic [7:0]                         data_byte_i,
  input  logic                               first_of_buffer_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [wbps_pkg::MatchWidth-1:0]    match_offset_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wbps_pkg::CfgWidth-1:0]      cfg_data_i
);

  `include "wildcard_byte_pattern_scanner_unit_macros.svh"

  wbps_pkg::req_t                  in_req, s1_req;
  logic                            s1_valid, s1_take;
  logic                            out_free, core_hit;
  logic [wbps_pkg::MatchWidth-1:0] core_offset;
  logic [wbps_pkg::CfgWidth-1:0]   pat_len_q;
  logic [wbps_pkg::LenW-1:0]       len_used;

  // The length register accepts a write in every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= '0;
    end else if (cfg_valid_i) begin
      pat_len_q <= cfg_data_i;
    end
  end

  // Lengths beyond the store depth are clamped to the full store.
  assign len_used = (int'(pat_len_q) > wbps_pkg::MaxPattern) ?
                    wbps_pkg::LenW'(wbps_pkg::MaxPattern) : wbps_pkg::LenW'(pat_len_q);

  always_comb begin
    in_req                 = '0;
    in_req.opcode          = wbps_pkg::op_e'(opcode_i);
    in_req.token_index     = token_index_i;
    in_req.token_byte      = token_byte_i;
    in_req.token_wildcard  = token_wildcard_i;
    in_req.data_byte       = data_byte_i;
    in_req.first_of_buffer = first_of_buffer_i;
  end

  // A scan leaves the input register only when the result register can take
  // whatever it produces; a load never produces a result and always leaves.
  assign s1_take = s1_valid && (out_free || (s1_req.opcode == wbps_pkg::OpLoad));

  wbps_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (in_req),
    .take_i  (s1_take),
    .valid_o (s1_valid),
    .req_o   (s1_req)
  );

  wbps_match_core u_match_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (s1_req),
    .fire_i   (s1_take),
    .len_i    (len_used),
    .hit_o    (core_hit),
    .offset_o (core_offset)
  );

  wbps_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (s1_take && core_hit),
    .offset_i (core_offset),
    .free_o   (out_free),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .offset_o (match_offset_o)
  );

  // An empty pattern never reports a match.
  `WBPS_ASSERT_NOW(a_empty_no_hit, len_used == '0, !core_hit, "match with empty pattern")
  // A new result only ever follows a scan leaving the input register.
  `WBPS_ASSERT_NOW(a_result_from_scan, $rose(out_valid_o),
    $past(s1_take && (s1_req.opcode == wbps_pkg::OpScan)), "result without scan")
  // The input side stalls only when both registers are full and blocked.
  `WBPS_ASSERT_NOW(a_stall_only_full, !in_ready_o,
    s1_valid && out_valid_o && !out_ready_i, "input stalled without backpressure")
  // A load request leaves the input register without waiting on the output.
  `WBPS_ASSERT_NEXT(a_load_moves, s1_valid && (s1_req.opcode == wbps_pkg::OpLoad),
    in_ready_o || $past(s1_take), "load request stuck")

endmodule
